>>> rtl/iban_mod97_checker_core_macros.svh
// Assertion macros for the assertion module of the IBAN mod-97 block.
`ifndef IBAN_MOD97_CHECKER_CORE_MACROS_SVH
`define IBAN_MOD97_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IMC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define IMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imc assertion failed");

`endif

>>> rtl/imc_pkg.sv
// Types, constants and helper functions of the IBAN mod-97 checker.
package imc_pkg;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [1:0] REG_MAX_RAW  = 2'd0;
  localparam logic [1:0] REG_MIN_KEPT = 2'd1;
  localparam logic [1:0] REG_MAX_KEPT = 2'd2;

  localparam logic [7:0] RST_MAX_RAW  = 8'd60;
  localparam logic [5:0] RST_MIN_KEPT = 6'd15;
  localparam logic [5:0] RST_MAX_KEPT = 6'd34;

  localparam logic [7:0] RAW_SAT  = 8'd255;
  localparam logic [5:0] KEPT_SAT = 6'd63;
  localparam logic [5:0] HEAD_LEN = 6'd4;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5a;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7a;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  localparam logic [6:0] MOD_BASE = 7'd97;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LENGTH   = 3'd1,
    ERR_COUNTRY  = 3'd2,
    ERR_BAD_CHAR = 3'd3,
    ERR_CHECK    = 3'd4
  } err_t;

  typedef struct packed {
    logic [7:0] max_raw_length;
    logic [5:0] min_kept_length;
    logic [5:0] max_kept_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] raw_count;
    logic [5:0] kept_count;
    logic       bad_char_seen;
    logic [6:0] tail_remainder;
    logic [3:0][7:0] head_chars;
  } str_state_t;

  typedef struct packed {
    logic       adv;
    logic [7:0] character;
    logic       end_of_string;
  } item_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_UP_A) && (c <= CH_UP_Z);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CH_LO_A) && (c <= CH_LO_Z);
  endfunction

  function automatic logic is_decimal(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // x mod 97 for x < 4096: quotient by reciprocal 675/2^16 is exact or one low.
  function automatic logic [6:0] mod97(input logic [11:0] x);
    logic [21:0] prod;
    logic [5:0]  q;
    logic [12:0] r;
    prod = 22'(x) * 22'd675;
    q    = prod[21:16];
    r    = 13'(x) - (13'(q) * 13'(MOD_BASE));
    if (r >= 13'(MOD_BASE)) begin
      r = r - 13'(MOD_BASE);
    end
    return r[6:0];
  endfunction

endpackage

>>> rtl/imc_in_if.sv
// Input channel: one IBAN character or a terminator per request.
interface imc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_string;

  modport source (output valid, output character, output end_of_string, input ready);
  modport sink   (input valid, input character, input end_of_string, output ready);
endinterface

>>> rtl/imc_out_if.sv
// Output channel: one verdict per terminator.
interface imc_out_if;
  logic       valid;
  logic       ready;
  logic       is_valid;
  logic [2:0] error_code;

  modport source (output valid, output is_valid, output error_code, input ready);
  modport sink   (input valid, input is_valid, input error_code, output ready);
endinterface

>>> rtl/imc_cfg_regs.sv
// APB configuration registers: raw and kept length limits.
module imc_cfg_regs
  import imc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_raw_length  <= RST_MAX_RAW;
      cfg.min_kept_length <= RST_MIN_KEPT;
      cfg.max_kept_length <= RST_MAX_KEPT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAX_RAW:  cfg.max_raw_length  <= pwdata[7:0];
        REG_MIN_KEPT: cfg.min_kept_length <= pwdata[5:0];
        REG_MAX_KEPT: cfg.max_kept_length <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_RAW:  prdata = APB_DATA_W'(cfg.max_raw_length);
      REG_MIN_KEPT: prdata = APB_DATA_W'(cfg.min_kept_length);
      REG_MAX_KEPT: prdata = APB_DATA_W'(cfg.max_kept_length);
      default:      prdata = '0;
    endcase
  end

endmodule

>>> rtl/imc_char_unit.sv
// Per-character state: counters, bad-character flag, head buffer, tail remainder.
module imc_char_unit
  import imc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  output str_state_t st
);

  logic [7:0]  c_up;
  logic        kept;
  logic        sep;
  logic        in_head;
  logic [11:0] fold_sum;
  logic [6:0]  tail_next;
  logic [7:0]  digit_val;
  logic [7:0]  letter_val;

  always_comb begin
    c_up       = is_lower(item.character) ? (item.character - CASE_GAP) : item.character;
    kept       = is_upper(c_up) || is_decimal(c_up);
    sep        = (c_up == CH_SPACE) || (c_up == CH_HYPHEN);
    in_head    = st.kept_count < HEAD_LEN;
    digit_val  = c_up - CH_ZERO;
    letter_val = c_up - CH_UP_A + 8'd10;
    // a letter is two decimal digits: 100*r mod 97 == 3*r mod 97
    if (is_decimal(c_up)) begin
      fold_sum = 12'(st.tail_remainder) * 12'd10 + 12'(digit_val[3:0]);
    end else begin
      fold_sum = 12'(st.tail_remainder) * 12'd3 + 12'(letter_val[5:0]);
    end
    tail_next = mod97(fold_sum);
  end

  // head buffer holds payload only, so reset leaves it alone
  always_ff @(posedge clk) begin
    if (rst) begin
      st.raw_count      <= '0;
      st.kept_count     <= '0;
      st.bad_char_seen  <= 1'b0;
      st.tail_remainder <= '0;
    end else if (item.adv) begin
      if (item.end_of_string) begin
        st.raw_count      <= '0;
        st.kept_count     <= '0;
        st.bad_char_seen  <= 1'b0;
        st.tail_remainder <= '0;
      end else begin
        if (st.raw_count != RAW_SAT) begin
          st.raw_count <= st.raw_count + 8'd1;
        end
        if (kept) begin
          if (!in_head) begin
            st.tail_remainder <= tail_next;
          end else begin
            st.head_chars[st.kept_count[1:0]] <= c_up;
          end
          if (st.kept_count != KEPT_SAT) begin
            st.kept_count <= st.kept_count + 6'd1;
          end
        end else if (!sep) begin
          st.bad_char_seen <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/imc_verdict.sv
// Verdict logic and result register: length, character, country and mod-97 checks.
module imc_verdict
  import imc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  str_state_t st,
  input  cfg_t       cfg,
  input  logic       out_ready,
  output logic       slot_free,
  output logic       out_valid,
  output logic       is_valid,
  output logic [2:0] error_code
);

  err_t        err;
  logic [7:0]  v0;
  logic [7:0]  v1;
  logic [7:0]  d2;
  logic [7:0]  d3;
  logic [11:0] total;
  logic [6:0]  final_rem;
  logic        out_valid_next;

  always_comb begin
    v0 = st.head_chars[0] - CH_UP_A + 8'd10;
    v1 = st.head_chars[1] - CH_UP_A + 8'd10;
    d2 = st.head_chars[2] - CH_ZERO;
    d3 = st.head_chars[3] - CH_ZERO;
    // head folded after the tail: weights are 10^6, 10^4, 10^2, 10, 1 mod 97
    total = 12'(st.tail_remainder) * 12'd27
          + 12'(v0[5:0]) * 12'd9
          + 12'(v1[5:0]) * 12'd3
          + 12'(d2[3:0]) * 12'd10
          + 12'(d3[3:0]);
    final_rem = mod97(total);

    if (st.raw_count > cfg.max_raw_length) begin
      err = ERR_LENGTH;
    end else if (st.bad_char_seen) begin
      err = ERR_BAD_CHAR;
    end else if ((st.kept_count < cfg.min_kept_length) ||
                 (st.kept_count > cfg.max_kept_length)) begin
      err = ERR_LENGTH;
    end else if (!is_upper(st.head_chars[0]) || !is_upper(st.head_chars[1])) begin
      err = ERR_COUNTRY;
    end else if (!is_decimal(st.head_chars[2]) || !is_decimal(st.head_chars[3])) begin
      err = ERR_CHECK;
    end else if (final_rem != 7'd1) begin
      err = ERR_CHECK;
    end else begin
      err = ERR_NONE;
    end
  end

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    if (take) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      is_valid   <= (err == ERR_NONE);
      error_code <= err;
    end
  end

endmodule

>>> rtl/iban_mod97_checker_core.sv
// Top level of the IBAN mod-97 checker: input register, configuration registers, character unit, verdict.
//
//   channel   dir  handshake        payload
//   iban_in   in   valid / ready    character[7:0], end_of_string
//   verdict   out  valid / ready    is_valid, error_code[2:0]
//   apb       in   psel / penable   paddr[3:0], pwdata, prdata (regs at 0, 4, 8)
//
// One request per cycle while iban_in is not stalled; each request passes through the input register.
// A verdict is registered in the result register when its terminator leaves the input register.
// A terminator waits in the input register while the previous verdict is unread,
// and only then is iban_in stalled.
// rst is synchronous: counters clear, limits return to 60 / 15 / 34.
module iban_mod97_checker_core
  import imc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  imc_in_if.sink                iban_in,
  imc_out_if.source             verdict,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  str_state_t st;
  item_t      item;
  logic       s1_valid;
  logic       s1_valid_next;
  logic [7:0] s1_char;
  logic       s1_eos;
  logic       s1_adv;
  logic       slot_free;
  logic       accept;

  // a character never waits; a terminator needs a free result register
  assign s1_adv        = s1_valid && (!s1_eos || slot_free);
  assign iban_in.ready = !s1_valid || s1_adv;
  assign accept        = iban_in.valid && iban_in.ready;

  always_comb begin
    if (accept) begin
      s1_valid_next = 1'b1;
    end else if (s1_adv) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_char <= iban_in.character;
      s1_eos  <= iban_in.end_of_string;
    end
  end

  assign item.adv           = s1_adv;
  assign item.character     = s1_char;
  assign item.end_of_string = s1_eos;

  imc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  imc_char_unit u_char (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .st   (st)
  );

  imc_verdict u_verdict (
    .clk        (clk),
    .rst        (rst),
    .take       (s1_adv && s1_eos),
    .st         (st),
    .cfg        (cfg),
    .out_ready  (verdict.ready),
    .slot_free  (slot_free),
    .out_valid  (verdict.valid),
    .is_valid   (verdict.is_valid),
    .error_code (verdict.error_code)
  );

endmodule

>>> rtl/imc_sva.sv
// Port-level assertions for the IBAN mod-97 checker, bound to the top level.
`include "iban_mod97_checker_core_macros.svh"

module imc_sva
  import imc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       is_valid,
  input logic [2:0] error_code
);

  // a pending verdict stays until taken
  `IMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `IMC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                   $stable(is_valid) && $stable(error_code))
  // pass flag and error code agree
  `IMC_ASSERT_SAME(a_pass_code, out_valid, is_valid == (error_code == ERR_NONE))
  // input stalls only behind an unread verdict
  `IMC_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready)

endmodule

bind iban_mod97_checker_core imc_sva u_imc_sva (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (iban_in.ready),
  .out_valid  (verdict.valid),
  .out_ready  (verdict.ready),
  .is_valid   (verdict.is_valid),
  .error_code (verdict.error_code)
);
